/* sv/rssfc_pkg.sv */
// Shared types, codes and constants of the relay stream SENDME flow control block.
`default_nettype none
package rssfc_pkg;

  // Behavior constants
  localparam int MAX_PAYLOAD         = 498;
  localparam int STREAM_SENDME_STEP  = 50;
  localparam int CIRCUIT_SENDME_STEP = 100;
  localparam int CIRCUIT_WINDOW_INIT = 1000;

  // Default depth of the queues between the parts
  localparam int QUEUE_DEPTH_DEF = 2;

  // Field widths
  localparam int CMD_W  = 3;
  localparam int SID_W  = 16;
  localparam int CNT_W  = 9;
  localparam int WIN_W  = 11;
  localparam int START_W = 10;
  localparam int STAT_W = 3;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Residue widths of the windows modulo their SENDME steps
  localparam int SRES_W = (STREAM_SENDME_STEP > 1) ? $clog2(STREAM_SENDME_STEP) : 1;
  localparam int CRES_W = (CIRCUIT_SENDME_STEP > 1) ? $clog2(CIRCUIT_SENDME_STEP) : 1;

  // Reciprocal of the stream step for the start-window residue
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] STREAM_RECIP =
    RECIP_W'(((longint'(1) << RECIP_SHIFT) + STREAM_SENDME_STEP - 1) / STREAM_SENDME_STEP);

  // Reset values
  localparam logic [SID_W-1:0]   OWN_ID_RST  = SID_W'(1);
  localparam logic [START_W-1:0] START_RST   = START_W'(500);
  localparam logic [START_W-1:0] START_Q_RST = START_W'(500 / STREAM_SENDME_STEP);
  localparam logic [WIN_W-1:0]   SWIN_RST    = WIN_W'(500);
  localparam logic [SRES_W-1:0]  SRES_RST    = SRES_W'(500 % STREAM_SENDME_STEP);
  localparam logic [WIN_W-1:0]   CWIN_RST    = WIN_W'(CIRCUIT_WINDOW_INIT);
  localparam logic [CRES_W-1:0]  CRES_RST    =
    CRES_W'(CIRCUIT_WINDOW_INIT % CIRCUIT_SENDME_STEP);

  // Register indexes
  localparam logic [1:0] REG_OWN_ID = 2'd0;
  localparam logic [1:0] REG_START  = 2'd1;
  localparam logic [1:0] REG_STOP   = 2'd2;

  // Commands
  localparam logic [CMD_W-1:0] CMD_DATA   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SENDME = 3'd1;
  localparam logic [CMD_W-1:0] CMD_END    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TRUNC  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_OTHER  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_OPEN   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD   = 3'd7;

  // Status codes
  localparam logic [STAT_W-1:0] ST_WAIT     = 3'd0;
  localparam logic [STAT_W-1:0] ST_ARRIVED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_ENDED    = 3'd2;
  localparam logic [STAT_W-1:0] ST_TRUNC    = 3'd3;
  localparam logic [STAT_W-1:0] ST_WRONG    = 3'd4;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd5;
  localparam logic [STAT_W-1:0] ST_WINDOW   = 3'd6;
  localparam logic [STAT_W-1:0] ST_UNKNOWN  = 3'd7;

  // Operation kinds handed from front to back
  typedef enum logic [2:0] {
    OPK_STATUS,
    OPK_DATA,
    OPK_END,
    OPK_READ,
    OPK_OPEN
  } op_kind_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [SID_W-1:0] cell_stream;
    logic [CNT_W-1:0] payload_size;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              send_stream_sendme;
    logic              send_circuit_sendme;
    logic [CNT_W-1:0]  bytes_read;
    logic [CNT_W-1:0]  bytes_buffered;
    logic              stream_connected;
  } out_t;

  typedef struct packed {
    logic [SID_W-1:0]   own_stream_id;
    logic [START_W-1:0] stream_window_start;
    logic [START_W-1:0] start_quot;
    logic               stop_on_sendme;
  } cfg_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [STAT_W-1:0]  status;
    logic [CNT_W-1:0]   size;
    logic [START_W-1:0] start;
    logic [SRES_W-1:0]  start_res;
  } op_t;

endpackage
`default_nettype wire

/* sv/rssfc_cfg.sv */
// Configuration register file with APB-style access.
`default_nettype none
module rssfc_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rssfc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [rssfc_pkg::PDATA_W-1:0] pwdata,
  output logic      [rssfc_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  output rssfc_pkg::cfg_t                   cfg
);
  import rssfc_pkg::*;

  logic [SID_W-1:0]   own_id_r;
  logic [START_W-1:0] start_r;
  logic [START_W-1:0] start_q_r;
  logic               stop_r;
  logic               wr_en;
  logic [1:0]         reg_idx;
  logic [START_W+RECIP_W-1:0] recip_prod;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // Quotient of the start window by the stream step, kept for the residue
  assign recip_prod = (START_W+RECIP_W)'(pwdata[START_W-1:0]) *
                      (START_W+RECIP_W)'(STREAM_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r  <= OWN_ID_RST;
      start_r   <= START_RST;
      start_q_r <= START_Q_RST;
      stop_r    <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_OWN_ID: own_id_r <= pwdata[SID_W-1:0];
        REG_START: begin
          start_r   <= pwdata[START_W-1:0];
          start_q_r <= recip_prod[RECIP_SHIFT +: START_W];
        end
        REG_STOP:   stop_r <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_OWN_ID: prdata = PDATA_W'(own_id_r);
      REG_START:  prdata = PDATA_W'(start_r);
      REG_STOP:   prdata = PDATA_W'(stop_r);
      default:    prdata = '0;
    endcase
  end

  assign cfg.own_stream_id       = own_id_r;
  assign cfg.stream_window_start = start_r;
  assign cfg.start_quot          = start_q_r;
  assign cfg.stop_on_sendme      = stop_r;

endmodule
`default_nettype wire

/* sv/rssfc_fifo.sv */
// Small first-in first-out queue of registers.
`default_nettype none
module rssfc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign dout  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

/* sv/rssfc_front.sv */
// Front part: accept a cell header or request and classify it into an operation.
`default_nettype none
module rssfc_front (
  input  wire logic           push,
  output logic                full,
  input  wire rssfc_pkg::in_t in_data,
  input  wire rssfc_pkg::cfg_t cfg,
  output logic                q_push,
  output rssfc_pkg::op_t      q_data,
  input  wire logic           q_full
);
  import rssfc_pkg::*;

  logic [STAT_W-1:0]      awaited;
  logic                   own;
  logic [2*START_W-1:0]   quot_prod;

  assign full   = q_full;
  assign q_push = push && !q_full;

  assign awaited = (in_data.cmd == {2'b00, cfg.stop_on_sendme}) ? ST_ARRIVED : ST_WAIT;
  assign own     = (in_data.cell_stream == cfg.own_stream_id);

  // Residue of the start window: start minus quotient times step
  assign quot_prod = cfg.start_quot * START_W'(STREAM_SENDME_STEP);

  always_comb begin
    q_data           = '0;
    q_data.kind      = OPK_STATUS;
    q_data.status    = ST_WAIT;
    q_data.size      = in_data.payload_size;
    q_data.start     = cfg.stream_window_start;
    q_data.start_res = SRES_W'(cfg.stream_window_start - quot_prod[START_W-1:0]);
    case (in_data.cmd)
      CMD_READ: q_data.kind = OPK_READ;
      CMD_OPEN: q_data.kind = OPK_OPEN;
      CMD_RSVD: q_data.status = ST_UNKNOWN;
      default: begin
        if (in_data.cell_stream == '0) begin
          q_data.status = (in_data.cmd == CMD_TRUNC) ? ST_TRUNC : awaited;
        end else if (!own) begin
          q_data.status = ST_WRONG;
        end else begin
          case (in_data.cmd)
            CMD_SENDME: q_data.status = awaited;
            CMD_DATA: begin
              q_data.kind   = OPK_DATA;
              q_data.status = awaited;
            end
            CMD_END:   q_data.kind = OPK_END;
            default:   q_data.status = ST_UNKNOWN;
          endcase
        end
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/rssfc_back.sv */
// Back part: apply an operation to the windows and buffer, and form the result beat.
`default_nettype none
module rssfc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rssfc_pkg::op_t q_data,
  input  wire logic           q_empty,
  output logic                q_pop,
  output logic                o_push,
  output rssfc_pkg::out_t     o_data,
  input  wire logic           o_full
);
  import rssfc_pkg::*;

  logic [WIN_W-1:0]  swin_r, swin_nxt;
  logic [WIN_W-1:0]  cwin_r, cwin_nxt;
  logic [SRES_W-1:0] sres_r, sres_nxt, sres_dec;
  logic [CRES_W-1:0] cres_r, cres_nxt, cres_dec;
  logic [CNT_W-1:0]  buf_r, buf_nxt;
  logic              conn_r, conn_nxt;
  logic              do_exec;
  logic [CNT_W:0]    sum;
  logic [CNT_W-1:0]  rd;
  logic              s_sm, c_sm;

  assign do_exec = !q_empty && !o_full;
  assign q_pop   = do_exec;
  assign o_push  = do_exec;

  assign sum      = {1'b0, buf_r} + {1'b0, q_data.size};
  assign rd       = (buf_r > CNT_W'(MAX_PAYLOAD)) ? CNT_W'(MAX_PAYLOAD) : buf_r;
  assign sres_dec = (sres_r == '0) ? SRES_W'(STREAM_SENDME_STEP - 1) : sres_r - 1'b1;
  assign cres_dec = (cres_r == '0) ? CRES_W'(CIRCUIT_SENDME_STEP - 1) : cres_r - 1'b1;
  assign s_sm     = (sres_dec == '0);
  assign c_sm     = (cres_dec == '0);

  always_comb begin
    swin_nxt = swin_r;
    cwin_nxt = cwin_r;
    sres_nxt = sres_r;
    cres_nxt = cres_r;
    buf_nxt  = buf_r;
    conn_nxt = conn_r;
    o_data   = '0;
    o_data.status = q_data.status;
    case (q_data.kind)
      OPK_READ: begin
        o_data.status     = ST_WAIT;
        o_data.bytes_read = rd;
        buf_nxt           = buf_r - rd;
      end
      OPK_OPEN: begin
        o_data.status = ST_WAIT;
        swin_nxt      = WIN_W'(q_data.start);
        sres_nxt      = q_data.start_res;
        conn_nxt      = 1'b1;
        buf_nxt       = '0;
      end
      OPK_END: begin
        o_data.status = ST_ENDED;
        conn_nxt      = 1'b0;
        buf_nxt       = '0;
      end
      OPK_DATA: begin
        if (sum > (CNT_W+1)'(MAX_PAYLOAD)) begin
          o_data.status = ST_OVERFLOW;
        end else if (cwin_r == '0 || swin_r == '0) begin
          o_data.status = ST_WINDOW;
        end else begin
          // Take one from each window, add a step back on a SENDME boundary
          o_data.send_stream_sendme  = s_sm;
          o_data.send_circuit_sendme = c_sm;
          swin_nxt = swin_r - 1'b1 + (s_sm ? WIN_W'(STREAM_SENDME_STEP) : '0);
          cwin_nxt = cwin_r - 1'b1 + (c_sm ? WIN_W'(CIRCUIT_SENDME_STEP) : '0);
          sres_nxt = sres_dec;
          cres_nxt = cres_dec;
          buf_nxt  = sum[CNT_W-1:0];
        end
      end
      default: ;
    endcase
    o_data.bytes_buffered   = buf_nxt;
    o_data.stream_connected = conn_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swin_r <= SWIN_RST;
      cwin_r <= CWIN_RST;
      sres_r <= SRES_RST;
      cres_r <= CRES_RST;
      buf_r  <= '0;
      conn_r <= 1'b0;
    end else if (do_exec) begin
      swin_r <= swin_nxt;
      cwin_r <= cwin_nxt;
      sres_r <= sres_nxt;
      cres_r <= cres_nxt;
      buf_r  <= buf_nxt;
      conn_r <= conn_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/relay_stream_sendme_flow_control.sv */
// Top level of the relay stream SENDME flow control block.
`default_nettype none
// Takes one relay cell header (command, stream id, payload size) or a local
// read or open request per beat and returns exactly one result beat for each,
// in order. While neither side stalls, the block sustains one beat per
// clock: a front stage classifies the beat against the configured stream id
// and awaited command, a short queue holds the classified operation, and a
// back stage updates the stream and circuit deliver windows, the buffered
// byte count and the connected flag, then parks the result in an output
// queue. A result reaches the out ports by way of the operation queue,
// written by the edge that takes its beat, and then the output queue,
// written by the back stage unless that queue is full. Either side may
// stall freely; the queues take up the slack. SENDME boundaries are found by
// keeping each window's remainder modulo its step next to the window itself;
// the remainder of the open-window register is derived from a quotient
// captured when that register is written. Write the configuration registers
// (own stream id at byte 0, open window at byte 4, stop-on-SENDME at byte 8)
// only while the block is idle.
module relay_stream_sendme_flow_control #(
  parameter int QUEUE_DEPTH = rssfc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input beats
  input  wire logic                          push,
  output logic                               full,
  input  wire rssfc_pkg::in_t                in_data,
  // Result beats
  output logic                               empty,
  input  wire logic                          pop,
  output rssfc_pkg::out_t                    out_data,
  // Configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rssfc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [rssfc_pkg::PDATA_W-1:0] pwdata,
  output logic      [rssfc_pkg::PDATA_W-1:0] prdata,
  output logic                               pready
);
  import rssfc_pkg::*;

  cfg_t cfg;
  op_t  f_op;
  op_t  b_op;
  out_t b_res;
  logic f_push, q_full, q_empty, q_pop;
  logic o_push, o_full;

  // Hold the register file
  rssfc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Classify each accepted beat
  rssfc_front u_front (
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .cfg     (cfg),
    .q_push  (f_push),
    .q_data  (f_op),
    .q_full  (q_full)
  );

  // Decouple classification from execution
  rssfc_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_op_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (f_push),
    .din   (f_op),
    .full  (q_full),
    .rd_en (q_pop),
    .dout  (b_op),
    .empty (q_empty)
  );

  // Advance the windows and buffer
  rssfc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_data  (b_op),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .o_push  (o_push),
    .o_data  (b_res),
    .o_full  (o_full)
  );

  // Hold finished results until the consumer pops them
  rssfc_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (o_push),
    .din   (b_res),
    .full  (o_full),
    .rd_en (pop),
    .dout  (out_data),
    .empty (empty)
  );

endmodule
`default_nettype wire

/* sv/rssfc_checker.sv */
// Port-level checks of the relay stream SENDME flow control block, bound to the top level.
`default_nettype none
module rssfc_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            full,
  input wire logic            empty,
  input wire logic            pop,
  input wire rssfc_pkg::out_t out_data
);
  import rssfc_pkg::*;

  // Reset drains both queues
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not drained after reset");

  // A waiting result beat holds until it is popped
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result beat changed");

  // A stream end leaves the stream disconnected with nothing buffered
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.status == ST_ENDED) |->
      (!out_data.stream_connected && out_data.bytes_buffered == '0))
    else $error("end beat left state behind");

  // SENDME requests only come with an accepted data cell
  a_sendme_status: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_data.send_stream_sendme || out_data.send_circuit_sendme)) |->
      (out_data.status == ST_WAIT || out_data.status == ST_ARRIVED))
    else $error("SENDME request with a failing status");

  // A read hands out bytes and empties the buffer
  a_read_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.bytes_read != '0) |->
      (out_data.status == ST_WAIT && out_data.bytes_buffered == '0 &&
       !out_data.send_stream_sendme && !out_data.send_circuit_sendme))
    else $error("read beat left bytes buffered");

endmodule

bind relay_stream_sendme_flow_control rssfc_checker u_rssfc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);
`default_nettype wire

/* verif/relay_stream_sendme_flow_control_tb.sv */
// Self-checking testbench of the relay stream SENDME flow control block.
`default_nettype none
module relay_stream_sendme_flow_control_tb;
  import rssfc_pkg::*;

  // Cycles without any accepted beat before the run is declared hung.
  // The longest legal quiet stretch is the receiver hold-off below.
  localparam int QUIET_LIMIT = 3000;
  // The receiver holds off once, after this many result beats, for this long
  localparam int HOLD_AT     = 800;
  localparam int HOLD_CYCLES = 300;
  // Input beat numbers between which neither side idles
  localparam int STEADY_LO = 400;
  localparam int STEADY_HI = 560;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic push = 1'b0;
  logic full;
  in_t  in_data = '0;
  logic empty;
  logic pop = 1'b0;
  out_t out_data;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  relay_stream_sendme_flow_control DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow copy of the configuration registers, at their reset values
  logic [SID_W-1:0]   own_id     = OWN_ID_RST;
  logic [START_W-1:0] open_win   = START_RST;
  logic               stop_on_sm = 1'b0;

  // Shadow copy of the flow control state, at its reset values
  logic [WIN_W-1:0] win_stream = SWIN_RST;
  logic [WIN_W-1:0] win_circ   = CWIN_RST;
  logic [CNT_W-1:0] held_bytes = '0;
  logic             connected  = 1'b0;

  in_t  cell_backlog[$];   // cells waiting to be offered to the block
  out_t due_results[$];    // predicted results, oldest first

  int fails       = 0;
  int cells_in    = 0;
  int results_out = 0;
  int hold_left   = 0;
  int quiet       = 0;

  // Status of a cell that may be the one the reader is waiting for
  function automatic logic [STAT_W-1:0] awaited_code(logic [CMD_W-1:0] cmd);
    return (cmd == (stop_on_sm ? CMD_SENDME : CMD_DATA)) ? ST_ARRIVED : ST_WAIT;
  endfunction

  // Apply one cell or request to the shadow state and return its result
  function automatic out_t advance_windows(in_t c);
    out_t r;
    int   sw;
    int   cw;
    int   rd;
    r = '0;
    if (c.cmd == CMD_READ) begin
      // Hand out everything buffered, capped at one payload
      rd = int'(held_bytes);
      if (rd > MAX_PAYLOAD) rd = MAX_PAYLOAD;
      held_bytes = held_bytes - CNT_W'(rd);
      r.bytes_read = CNT_W'(rd);
    end else if (c.cmd == CMD_OPEN) begin
      win_stream = WIN_W'(open_win);
      connected  = 1'b1;
      held_bytes = '0;
    end else if (c.cmd == CMD_RSVD) begin
      r.status = ST_UNKNOWN;
    end else if (c.cell_stream == '0) begin
      // Circuit level cell: a truncation is reported, else the awaited status
      r.status = (c.cmd == CMD_TRUNC) ? ST_TRUNC : awaited_code(c.cmd);
    end else if (c.cell_stream != own_id) begin
      r.status = ST_WRONG;
    end else if (c.cmd == CMD_SENDME) begin
      r.status = awaited_code(c.cmd);
    end else if (c.cmd == CMD_DATA) begin
      if (int'(held_bytes) + int'(c.payload_size) > MAX_PAYLOAD) begin
        r.status = ST_OVERFLOW;
      end else if (win_circ == '0 || win_stream == '0) begin
        r.status = ST_WINDOW;
      end else begin
        // Take one from both windows, refill at each SENDME boundary
        sw = int'(win_stream) - 1;
        cw = int'(win_circ) - 1;
        if (sw % STREAM_SENDME_STEP == 0) begin
          r.send_stream_sendme = 1'b1;
          sw = sw + STREAM_SENDME_STEP;
        end
        if (cw % CIRCUIT_SENDME_STEP == 0) begin
          r.send_circuit_sendme = 1'b1;
          cw = cw + CIRCUIT_SENDME_STEP;
        end
        win_stream = WIN_W'(sw);
        win_circ   = WIN_W'(cw);
        held_bytes = held_bytes + c.payload_size;
        r.status   = awaited_code(c.cmd);
      end
    end else if (c.cmd == CMD_END) begin
      connected  = 1'b0;
      held_bytes = '0;
      r.status   = ST_ENDED;
    end else begin
      // Truncated or other cell on our own stream
      r.status = ST_UNKNOWN;
    end
    r.bytes_buffered   = held_bytes;
    r.stream_connected = connected;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endfunction

  function automatic void queue_cell(logic [CMD_W-1:0] cmd, logic [SID_W-1:0] sid,
                                     logic [CNT_W-1:0] size);
    in_t c;
    c.cmd          = cmd;
    c.cell_stream  = sid;
    c.payload_size = size;
    cell_backlog.push_back(c);
  endfunction

  // Mostly small payloads so the buffer fills slowly; now and then a big one
  function automatic logic [CNT_W-1:0] draw_size();
    if ($urandom_range(0, 99) < 85) return CNT_W'($urandom_range(0, 60));
    return CNT_W'($urandom_range(0, MAX_PAYLOAD));
  endfunction

  // Input driver: predict each accepted beat, then offer the next cell
  always @(posedge clk) begin : cell_driver
    bit idle_now;
    if (rst_n && push && !full) begin
      due_results.push_back(advance_windows(in_data));
      void'(cell_backlog.pop_front());
      cells_in++;
    end
    idle_now = !(cells_in >= STEADY_LO && cells_in < STEADY_HI) &&
               ($urandom_range(0, 99) < 26);
    if (rst_n && cell_backlog.size() != 0 && !idle_now) begin
      push    <= 1'b1;
      in_data <= cell_backlog[0];
    end else begin
      push <= 1'b0;
    end
  end

  // Result monitor: compare each accepted beat with the oldest prediction
  always @(posedge clk) begin : result_monitor
    out_t want;
    bit   idle_now;
    if (rst_n && pop && !empty) begin
      if (due_results.size() == 0) begin
        $error("result beat with no expected result waiting: %p", out_data);
        fails++;
      end else begin
        want = due_results.pop_front();
        check_field("status", 16'(want.status), 16'(out_data.status));
        check_field("send_stream_sendme", 16'(want.send_stream_sendme),
                    16'(out_data.send_stream_sendme));
        check_field("send_circuit_sendme", 16'(want.send_circuit_sendme),
                    16'(out_data.send_circuit_sendme));
        check_field("bytes_read", 16'(want.bytes_read), 16'(out_data.bytes_read));
        check_field("bytes_buffered", 16'(want.bytes_buffered),
                    16'(out_data.bytes_buffered));
        check_field("stream_connected", 16'(want.stream_connected),
                    16'(out_data.stream_connected));
      end
      results_out++;
      // Hold off once for a long stretch so the block backs up and stalls its input
      if (results_out == HOLD_AT) hold_left = HOLD_CYCLES;
    end
    idle_now = !(cells_in >= STEADY_LO && cells_in < STEADY_HI) &&
               ($urandom_range(0, 99) < 26);
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= rst_n && !idle_now;
    end
  end

  // Watchdog: any accepted beat on any port restarts the count
  always @(posedge clk) begin : hang_watch
    if (!rst_n || (push && !full) || (pop && !empty) || (psel && penable && pready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Register write: setup cycle, access cycle, done at the edge with pready high
  task automatic cfg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_OWN_ID: own_id     = val[SID_W-1:0];
      REG_START:  open_win   = val[START_W-1:0];
      REG_STOP:   stop_on_sm = val[0];
      default: ;
    endcase
  endtask

  task automatic cfg_setup(input int sid, input int start, input int stop);
    cfg_write(REG_OWN_ID, PDATA_W'(sid));
    cfg_write(REG_START, PDATA_W'(start));
    cfg_write(REG_STOP, PDATA_W'(stop));
  endtask

  // Hold until every cell is taken and every result has come back
  task automatic drain();
    while (cell_backlog.size() != 0 || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Open the stream, then a run of mostly well-formed traffic on it,
  // mixed with circuit level cells, foreign streams and plain noise
  task automatic random_session(input int n);
    int pick;
    queue_cell(CMD_OPEN, SID_W'($urandom), draw_size());
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        queue_cell(CMD_DATA, own_id, draw_size());
      else if (pick < 70)
        queue_cell(CMD_READ, SID_W'($urandom), draw_size());
      else if (pick < 75)
        queue_cell(CMD_SENDME, own_id, draw_size());
      else if (pick < 80)
        queue_cell(CMD_W'($urandom_range(0, 4)), '0, draw_size());
      else if (pick < 85)
        queue_cell(CMD_W'($urandom_range(0, 4)), SID_W'($urandom_range(1, 65535)),
                   draw_size());
      else if (pick < 88)
        queue_cell(($urandom_range(0, 1) != 0) ? CMD_TRUNC : CMD_OTHER, own_id, draw_size());
      else if (pick < 90)
        queue_cell(CMD_RSVD, SID_W'($urandom), draw_size());
      else if (pick < 92)
        queue_cell(CMD_END, own_id, draw_size());
      else
        queue_cell(CMD_W'($urandom_range(0, 7)), SID_W'($urandom),
                   CNT_W'($urandom_range(0, MAX_PAYLOAD)));
    end
  endtask

  task automatic random_phase(input int total);
    int n;
    int count;
    count = 0;
    while (count < total) begin
      n = $urandom_range(10, 80);
      random_session(n);
      count = count + n + 1;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults, data cells awaited: corner cases one by one
    cfg_setup(1, 500, 0);
    queue_cell(CMD_DATA, 16'd1, 9'd0);          // data before any open
    queue_cell(CMD_OPEN, 16'd0, 9'd0);
    queue_cell(CMD_DATA, 16'd1, 9'd498);        // fill the buffer to the brim
    queue_cell(CMD_DATA, 16'd1, 9'd1);          // one byte too many
    queue_cell(CMD_READ, 16'd0, 9'd0);
    queue_cell(CMD_READ, 16'd65535, 9'd498);    // read with nothing buffered
    queue_cell(CMD_SENDME, 16'd1, 9'd0);
    queue_cell(CMD_TRUNC, 16'd0, 9'd0);         // truncated circuit level cell
    queue_cell(CMD_OTHER, 16'd0, 9'd0);
    queue_cell(CMD_DATA, 16'd0, 9'd256);        // circuit level data
    queue_cell(CMD_DATA, 16'd65535, 9'd255);    // foreign stream
    queue_cell(CMD_TRUNC, 16'd1, 9'd0);
    queue_cell(CMD_OTHER, 16'd1, 9'd0);
    queue_cell(CMD_RSVD, 16'd0, 9'd498);
    queue_cell(CMD_END, 16'd1, 9'd0);
    drain();

    // Highest stream id, empty open window, SENDME awaited
    cfg_setup(65535, 0, 1);
    queue_cell(CMD_OPEN, 16'd0, 9'd0);
    queue_cell(CMD_DATA, 16'd65535, 9'd10);     // window already at zero
    queue_cell(CMD_SENDME, 16'd65535, 9'd0);
    queue_cell(CMD_SENDME, 16'd0, 9'd0);
    queue_cell(CMD_READ, 16'd0, 9'd0);
    drain();

    // Open window of one: the first data cell hits a stream SENDME boundary
    cfg_setup($urandom_range(1, 65535), 1, 0);
    queue_cell(CMD_OPEN, 16'd0, 9'd0);
    queue_cell(CMD_DATA, own_id, 9'd20);
    queue_cell(CMD_DATA, own_id, 9'd30);
    queue_cell(CMD_READ, 16'd0, 9'd0);
    drain();

    // Open window of 1000; the sender pauses halfway until all results are back
    cfg_setup(1, 1000, 0);
    random_phase(150);
    drain();
    random_phase(150);
    drain();

    // Random stream id and window, SENDME awaited
    cfg_setup($urandom_range(1, 65535), $urandom_range(0, 1000), 1);
    random_phase(320);
    drain();

    // Highest stream id, default window; the receiver hold-off lands here
    cfg_setup(65535, 500, 0);
    random_phase(330);
    drain();
    repeat (8) @(posedge clk);

    if (fails == 0 && due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
sv/rssfc_pkg.sv
sv/rssfc_cfg.sv
sv/rssfc_fifo.sv
sv/rssfc_front.sv
sv/rssfc_back.sv
sv/relay_stream_sendme_flow_control.sv
sv/rssfc_checker.sv
verif/relay_stream_sendme_flow_control_tb.sv
